// ===== src/bankers_safety_check_top_macros.svh =====
`ifndef BANKERS_SAFETY_CHECK_TOP_MACROS_SVH
`define BANKERS_SAFETY_CHECK_TOP_MACROS_SVH

// same-cycle implication
`define BSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bsc_pkg.sv =====
package bsc_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 16;
    localparam int COUNT_BITS    = 16;

    localparam int PROC_BITS  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RES_BITS   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCNT_BITS  = $clog2(MAX_PROCESSES + 1);
    localparam int RCNT_BITS  = $clog2(MAX_RESOURCES + 1);
    localparam int ADDR_BITS  = PROC_BITS + RES_BITS;
    localparam int ENTRIES    = 1 << ADDR_BITS;
    localparam int NEED_BITS  = COUNT_BITS + 1;
    localparam int AVAIL_BITS = COUNT_BITS + 5;

    localparam int TYPE_BITS  = 2;
    localparam int INDEX_BITS = 4;
    localparam int FIELD_BITS = 16;
    localparam int CFG_BITS   = 5;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [TYPE_BITS-1:0] REQ_LOAD_ENTRY = 2'd0;
    localparam logic [TYPE_BITS-1:0] REQ_LOAD_AVAIL = 2'd1;
    localparam logic [TYPE_BITS-1:0] REQ_CHECK      = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_PROC = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_RES  = 1'b1;

    typedef struct packed {
        logic [TYPE_BITS-1:0]  req_type;
        logic [INDEX_BITS-1:0] proc_index;
        logic [INDEX_BITS-1:0] res_index;
        logic [FIELD_BITS-1:0] alloc_count;
        logic [FIELD_BITS-1:0] max_count;
        logic [FIELD_BITS-1:0] avail_count;
    } req_t;

    typedef struct packed {
        logic                  safe;
        logic [INDEX_BITS-1:0] proc_id;
        logic                  last;
    } rsp_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] alloc;
        logic [NEED_BITS-1:0]  need;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PSEL,
        ST_CHK_RD,
        ST_CHK_CMP,
        ST_GNT_RD,
        ST_GNT_WR,
        ST_EMIT,
        ST_UNSAFE
    } state_t;

endpackage

// ===== src/bankers_safety_check_top.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data   (bsc_pkg::req_t)
// out      output     out_valid / out_ready  out_data  (bsc_pkg::rsp_t)
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// Load words are taken while idle; in_ready is high whenever no check runs.
// A check runs passes; each ungranted process tests its need against available,
// resource by resource, until one fails; one that fits all is granted, adding its
// alloc to available. At most num_processes passes, then one word per granted process
// or one unsafe word. Alloc/need and available memories have one synchronous read
// port each. Reset clears control state only; a stalled out_ready holds out_reg and the check.

`include "bankers_safety_check_top_macros.svh"

module bankers_safety_check_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bsc_pkg::req_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bsc_pkg::rsp_t                  out_data,
    input  logic                           cfg_we,
    input  logic [bsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [bsc_pkg::CFG_BITS-1:0]   cfg_data
);
    import bsc_pkg::*;

    state_t                  state_reg, state_next;
    logic [PCNT_BITS-1:0]    i_reg, i_next;
    logic [RES_BITS-1:0]     j_reg, j_next;
    logic [PROC_BITS-1:0]    k_reg, k_next;
    logic [PCNT_BITS-1:0]    gcnt_reg, gcnt_next;
    logic                    found_reg, found_next;
    logic [MAX_PROCESSES-1:0] done_reg, done_next;
    logic [CFG_BITS-1:0]     np_cfg_reg, nr_cfg_reg;
    rsp_t                    out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic [PROC_BITS-1:0]    seq_mem [MAX_PROCESSES];
    logic                    seq_we;

    entry_t                  ent_mem [ENTRIES];
    entry_t                  ent_rd;
    entry_t                  ent_wdata;
    logic                    ent_we, ent_re;
    logic [ADDR_BITS-1:0]    ent_addr;

    logic [AVAIL_BITS-1:0]   avail_mem [MAX_RESOURCES];
    logic [AVAIL_BITS-1:0]   avail_rd;
    logic [AVAIL_BITS-1:0]   av_wdata;
    logic                    av_we, av_re;
    logic [RES_BITS-1:0]     av_addr;

    logic [PCNT_BITS-1:0]    np_eff;
    logic [RCNT_BITS-1:0]    nr_eff;
    logic                    in_fire, out_load;
    logic                    last_j, last_k, pass_end, fits;
    logic [AVAIL_BITS:0]     avail_sum;
    logic [AVAIL_BITS-1:0]   avail_sat;
    logic [PROC_BITS-1:0]    i_idx;

    assign in_fire  = in_valid && in_ready;
    assign out_load = !out_valid_reg || out_ready;
    assign i_idx    = i_reg[PROC_BITS-1:0];

    always_comb
    begin
        if (np_cfg_reg == '0)
            np_eff = PCNT_BITS'(1);
        else if (32'(np_cfg_reg) > MAX_PROCESSES)
            np_eff = PCNT_BITS'(MAX_PROCESSES);
        else
            np_eff = PCNT_BITS'(np_cfg_reg);
        if (nr_cfg_reg == '0)
            nr_eff = RCNT_BITS'(1);
        else if (32'(nr_cfg_reg) > MAX_RESOURCES)
            nr_eff = RCNT_BITS'(MAX_RESOURCES);
        else
            nr_eff = RCNT_BITS'(nr_cfg_reg);
    end

    assign last_j   = (RCNT_BITS'(j_reg) + RCNT_BITS'(1)) == nr_eff;
    assign last_k   = (PCNT_BITS'(k_reg) + PCNT_BITS'(1)) == np_eff;
    assign pass_end = (i_reg == np_eff);

    assign fits = $signed({{(AVAIL_BITS + 1 - NEED_BITS){ent_rd.need[NEED_BITS-1]}},
                           ent_rd.need}) <= $signed({1'b0, avail_rd});
    assign avail_sum = {1'b0, avail_rd} + (AVAIL_BITS + 1)'(ent_rd.alloc);
    assign avail_sat = avail_sum[AVAIL_BITS] ? '1 : avail_sum[AVAIL_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_data.req_type == REQ_CHECK)
                    state_next = ST_PSEL;
            end
            ST_PSEL:
            begin
                if (pass_end)
                begin
                    if (gcnt_reg == np_eff)
                        state_next = ST_EMIT;
                    else if (!found_reg)
                        state_next = ST_UNSAFE;
                end
                else if (!done_reg[i_idx])
                    state_next = ST_CHK_RD;
            end
            ST_CHK_RD:
                state_next = ST_CHK_CMP;
            ST_CHK_CMP:
            begin
                if (!fits)
                    state_next = ST_PSEL;
                else if (last_j)
                    state_next = ST_GNT_RD;
                else
                    state_next = ST_CHK_RD;
            end
            ST_GNT_RD:
                state_next = ST_GNT_WR;
            ST_GNT_WR:
            begin
                if (last_j)
                    state_next = ST_PSEL;
                else
                    state_next = ST_GNT_RD;
            end
            ST_EMIT:
            begin
                if (out_load && last_k)
                    state_next = ST_IDLE;
            end
            ST_UNSAFE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        gcnt_next      = gcnt_reg;
        found_next     = found_reg;
        done_next      = done_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        seq_we         = 1'b0;
        ent_we         = 1'b0;
        ent_re         = 1'b0;
        av_we          = 1'b0;
        av_re          = 1'b0;
        ent_addr       = {i_idx, j_reg};
        ent_wdata.alloc = COUNT_BITS'(in_data.alloc_count);
        ent_wdata.need  = NEED_BITS'(in_data.max_count) - NEED_BITS'(in_data.alloc_count);
        av_addr        = j_reg;
        av_wdata       = avail_sat;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.req_type)
                        REQ_LOAD_ENTRY:
                        begin
                            if (32'(in_data.proc_index) < MAX_PROCESSES &&
                                32'(in_data.res_index) < MAX_RESOURCES)
                            begin
                                ent_we   = 1'b1;
                                ent_addr = {PROC_BITS'(in_data.proc_index),
                                            RES_BITS'(in_data.res_index)};
                            end
                        end
                        REQ_LOAD_AVAIL:
                        begin
                            if (32'(in_data.res_index) < MAX_RESOURCES)
                            begin
                                av_we    = 1'b1;
                                av_addr  = RES_BITS'(in_data.res_index);
                                av_wdata = AVAIL_BITS'(COUNT_BITS'(in_data.avail_count));
                            end
                        end
                        REQ_CHECK:
                        begin
                            done_next  = '0;
                            gcnt_next  = '0;
                            i_next     = '0;
                            found_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PSEL:
            begin
                if (pass_end)
                begin
                    i_next     = '0;
                    found_next = 1'b0;
                    k_next     = '0;
                end
                else if (done_reg[i_idx])
                    i_next = i_reg + PCNT_BITS'(1);
                else
                    j_next = '0;
            end
            ST_CHK_RD, ST_GNT_RD:
            begin
                ent_re = 1'b1;
                av_re  = 1'b1;
            end
            ST_CHK_CMP:
            begin
                if (!fits)
                    i_next = i_reg + PCNT_BITS'(1);
                else if (last_j)
                    j_next = '0;
                else
                    j_next = j_reg + RES_BITS'(1);
            end
            ST_GNT_WR:
            begin
                av_we = 1'b1;
                if (last_j)
                begin
                    done_next[i_idx] = 1'b1;
                    seq_we           = 1'b1;
                    gcnt_next        = gcnt_reg + PCNT_BITS'(1);
                    found_next       = 1'b1;
                    i_next           = i_reg + PCNT_BITS'(1);
                    j_next           = '0;
                end
                else
                    j_next = j_reg + RES_BITS'(1);
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_next.safe    = 1'b1;
                    out_next.proc_id = INDEX_BITS'(seq_mem[k_reg]);
                    out_next.last    = last_k;
                    out_valid_next   = 1'b1;
                    k_next           = k_reg + PROC_BITS'(1);
                end
            end
            ST_UNSAFE:
            begin
                if (out_load)
                begin
                    out_next.safe    = 1'b0;
                    out_next.proc_id = '0;
                    out_next.last    = 1'b1;
                    out_valid_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            gcnt_reg      <= '0;
            found_reg     <= 1'b0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
            np_cfg_reg    <= CFG_BITS'(1);
            nr_cfg_reg    <= CFG_BITS'(1);
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            gcnt_reg      <= gcnt_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_PROC: np_cfg_reg <= cfg_data;
                    CFG_NUM_RES:  nr_cfg_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (seq_we)
            seq_mem[gcnt_reg[PROC_BITS-1:0]] <= i_idx;
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_addr] <= ent_wdata;
        if (ent_re)
            ent_rd <= ent_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (av_we)
            avail_mem[av_addr] <= av_wdata;
        if (av_re)
            avail_rd <= avail_mem[av_addr];
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `BSC_ASSERT_NOW(a_gcnt_bound, state_reg != ST_IDLE, gcnt_reg <= np_eff,
        "granted count exceeds processes in use")
    `BSC_ASSERT_NOW(a_unsafe_last, out_valid && !out_data.safe, out_data.last,
        "unsafe word not marked last")
    `BSC_ASSERT_NEXT(a_check_busy, in_fire && in_data.req_type == REQ_CHECK, !in_ready,
        "input taken during check")

endmodule
